// File: rtl/core/c2dvr_pkg.sv
// Package for the streaming 2D convolution with bias and ReLU.
// Holds image/kernel geometry, field widths, mode codes and the queue entry type.
// No dependencies.
`default_nettype none

package c2dvr_pkg;

    // geometry
    localparam int IMAGE_SIZE  = 28;
    localparam int KERNEL_SIZE = 7;
    localparam int KAREA       = KERNEL_SIZE * KERNEL_SIZE;
    localparam int LINE_LEN    = (KERNEL_SIZE - 1) * IMAGE_SIZE;
    localparam int POS_W       = $clog2(IMAGE_SIZE);

    // field widths
    localparam int PIX_W   = 8;
    localparam int WT_W    = 16;
    localparam int IDX_W   = 6;
    localparam int COORD_W = 5;
    localparam int BIAS_W  = 32;
    localparam int OUT_W   = 31;

    // arithmetic widths
    localparam int PROD_W = PIX_W + WT_W;
    localparam int ROW_W  = PROD_W + $clog2(KERNEL_SIZE + 1);
    localparam int SUM_W  = PROD_W + $clog2(KAREA + 1);
    localparam int TOT_W  = BIAS_W + 2;

    // item mode codes
    localparam logic MODE_WEIGHT = 1'b0;
    localparam logic MODE_PIXEL  = 1'b1;

    // one queue entry: a weight load or a full window
    typedef struct packed {
        logic                              is_weight;
        logic [IDX_W-1:0]                  weight_index;
        logic signed [WT_W-1:0]            weight_value;
        logic [KAREA-1:0][PIX_W-1:0]       window;
        logic [COORD_W-1:0]                out_row;
        logic [COORD_W-1:0]                out_col;
        logic                              last;
    } q_entry_t;

endpackage

`default_nettype wire

// File: rtl/core/conv2d_valid_relu_top.sv
// Top level of the streaming valid 2D convolution with bias and ReLU.
// Instantiates c2dvr_front, c2dvr_queue and c2dvr_back; uses c2dvr_pkg.
//
//  channel   signals                                           direction
//  s_        s_valid/s_ready, mode, weight_index/value, pixel  in
//  m_        m_valid/m_ready, conv_value, out_row/col, last    out
//  cfg_      cfg_wr_en, cfg_wr_data (bias)                     in
//
// One transaction per cycle on each side when neither is stalled.
// From pixel to result, the queue slot is written at the accepting edge, then
// products, row sums, total with bias and ReLU output are registered in turn.
// Synchronous active-low reset clears weights, bias, position and all valids.
// An output stall freezes the back pipeline; the two-entry queue absorbs it.
`default_nettype none

module conv2d_valid_relu_top
    import c2dvr_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic signed [BIAS_W-1:0] cfg_wr_data,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic                     s_mode,
    input  wire logic [IDX_W-1:0]         s_weight_index,
    input  wire logic signed [WT_W-1:0]   s_weight_value,
    input  wire logic [PIX_W-1:0]         s_pixel,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [OUT_W-1:0]              m_conv_value,
    output logic [COORD_W-1:0]            m_out_row,
    output logic [COORD_W-1:0]            m_out_col,
    output logic                          m_last
);

    logic     q_full, q_push, q_valid, q_pop;
    q_entry_t push_entry, pop_entry;

    c2dvr_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_weight_index (s_weight_index),
        .s_weight_value (s_weight_value),
        .s_pixel        (s_pixel),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_entry        (push_entry)
    );

    c2dvr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .q_valid    (q_valid),
        .pop        (q_pop),
        .pop_entry  (pop_entry)
    );

    c2dvr_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .q_valid      (q_valid),
        .q_entry      (pop_entry),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_conv_value (m_conv_value),
        .m_out_row    (m_out_row),
        .m_out_col    (m_out_col),
        .m_last       (m_last)
    );

    // last flag only on the bottom-right output position
    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |->
        (m_out_row == COORD_W'(IMAGE_SIZE - KERNEL_SIZE)) &&
        (m_out_col == COORD_W'(IMAGE_SIZE - KERNEL_SIZE)))
        else $error("last flag off the final position");

    // queue never written while full
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_push && q_full))
        else $error("queue overflow");

    // a result held under stall keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_conv_value))
        else $error("result changed under stall");

endmodule

`default_nettype wire

// File: rtl/core/c2dvr_front.sv
// Front part: accepts transactions, keeps the line delay and the window,
// and classifies each item into a weight load or a window job. Uses c2dvr_pkg.
`default_nettype none

module c2dvr_front
    import c2dvr_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_mode,
    input  wire logic [IDX_W-1:0]       s_weight_index,
    input  wire logic signed [WT_W-1:0] s_weight_value,
    input  wire logic [PIX_W-1:0]       s_pixel,
    input  wire logic                   q_full,
    output logic                        q_push,
    output q_entry_t                    q_entry
);

    logic                 accept;
    logic                 pix_acc;
    logic                 produce;
    logic [POS_W-1:0]     row_reg, row_next;
    logic [POS_W-1:0]     col_reg, col_next;
    logic [PIX_W-1:0]     line_reg [0:LINE_LEN-1];
    logic [PIX_W-1:0]     win_reg  [0:KAREA-1];
    logic [PIX_W-1:0]     win_next [0:KAREA-1];
    logic [PIX_W-1:0]     new_col  [0:KERNEL_SIZE-1];

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign pix_acc = accept && (s_mode == MODE_PIXEL);
    assign produce = (row_reg >= POS_W'(KERNEL_SIZE - 1)) &&
                     (col_reg >= POS_W'(KERNEL_SIZE - 1));

    // column entering the window: bottom row is the new pixel
    always_comb begin
        for (int z = 0; z < KERNEL_SIZE; z++) begin
            if (z == KERNEL_SIZE - 1) begin
                new_col[z] = s_pixel;
            end else begin
                new_col[z] = line_reg[(KERNEL_SIZE - 1 - z) * IMAGE_SIZE - 1];
            end
        end
    end

    // window shifted left by one column
    always_comb begin
        for (int z = 0; z < KERNEL_SIZE; z++) begin
            for (int j = 0; j < KERNEL_SIZE; j++) begin
                if (j == KERNEL_SIZE - 1) begin
                    win_next[z*KERNEL_SIZE+j] = new_col[z];
                end else begin
                    win_next[z*KERNEL_SIZE+j] = win_reg[z*KERNEL_SIZE+j+1];
                end
            end
        end
    end

    // raster position
    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if (col_reg == POS_W'(IMAGE_SIZE - 1)) begin
            col_next = '0;
            row_next = (row_reg == POS_W'(IMAGE_SIZE - 1)) ? '0 : row_reg + 1'b1;
        end else begin
            col_next = col_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (pix_acc) begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // line delay and window registers, payload only
    always_ff @(posedge aclk) begin
        if (pix_acc) begin
            line_reg[0] <= s_pixel;
            for (int i = 1; i < LINE_LEN; i++) begin
                line_reg[i] <= line_reg[i-1];
            end
            for (int k = 0; k < KAREA; k++) begin
                win_reg[k] <= win_next[k];
            end
        end
    end

    // queue entry
    always_comb begin
        q_push = accept && ((s_mode == MODE_WEIGHT) || produce);
        q_entry.is_weight    = (s_mode == MODE_WEIGHT);
        q_entry.weight_index = s_weight_index;
        q_entry.weight_value = s_weight_value;
        for (int k = 0; k < KAREA; k++) begin
            q_entry.window[k] = win_next[k];
        end
        q_entry.out_row = COORD_W'(row_reg - POS_W'(KERNEL_SIZE - 1));
        q_entry.out_col = COORD_W'(col_reg - POS_W'(KERNEL_SIZE - 1));
        q_entry.last    = (row_reg == POS_W'(IMAGE_SIZE - 1)) &&
                          (col_reg == POS_W'(IMAGE_SIZE - 1));
    end

endmodule

`default_nettype wire

// File: rtl/core/c2dvr_queue.sv
// Two-entry queue between the front and back parts.
// Uses c2dvr_pkg for the entry type.
`default_nettype none

module c2dvr_queue
    import c2dvr_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  wire q_entry_t push_entry,
    output logic          full,
    output logic          q_valid,
    input  wire logic     pop,
    output q_entry_t      pop_entry
);

    q_entry_t    slot_reg [0:1];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        do_pop;

    assign full      = (count_reg == 2'd2);
    assign q_valid   = (count_reg != 2'd0);
    assign do_pop    = pop && q_valid;
    assign pop_entry = slot_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/c2dvr_back.sv
// Back part: weight store, products, row sums, total with bias, ReLU/saturate
// and the output register. Uses c2dvr_pkg.
`default_nettype none

module c2dvr_back
    import c2dvr_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic signed [BIAS_W-1:0] cfg_wr_data,
    input  wire logic                     q_valid,
    input  wire q_entry_t                 q_entry,
    output logic                          q_pop,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [OUT_W-1:0]              m_conv_value,
    output logic [COORD_W-1:0]            m_out_row,
    output logic [COORD_W-1:0]            m_out_col,
    output logic                          m_last
);

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } tag_t;

    logic                      adv;
    logic signed [WT_W-1:0]    wt_reg   [0:KAREA-1];
    logic signed [BIAS_W-1:0]  bias_reg;
    logic signed [PROD_W-1:0]  prod_reg [0:KAREA-1];
    logic signed [ROW_W-1:0]   rsum_reg [0:KERNEL_SIZE-1];
    logic signed [ROW_W-1:0]   rsum_next[0:KERNEL_SIZE-1];
    logic signed [TOT_W-1:0]   tot_reg, tot_next;
    logic signed [SUM_W-1:0]   sum_acc;
    logic [OUT_W-1:0]          relu_val;
    logic                      v1_reg, v2_reg, v3_reg, out_v_reg;
    tag_t                      t1_reg, t2_reg, t3_reg, out_t_reg;
    logic [OUT_W-1:0]          out_val_reg;

    // whole pipeline moves when the output slot is empty or its result is taken
    assign adv   = !out_v_reg || m_ready;
    assign q_pop = adv;

    // bias register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_reg <= '0;
        end else if (cfg_wr_en) begin
            bias_reg <= cfg_wr_data;
        end
    end

    // weight store, updated in item order
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < KAREA; k++) begin
                wt_reg[k] <= '0;
            end
        end else if (adv && q_valid && q_entry.is_weight &&
                     (q_entry.weight_index < IDX_W'(KAREA))) begin
            wt_reg[q_entry.weight_index] <= q_entry.weight_value;
        end
    end

    // row sums
    always_comb begin
        for (int z = 0; z < KERNEL_SIZE; z++) begin
            rsum_next[z] = '0;
            for (int j = 0; j < KERNEL_SIZE; j++) begin
                rsum_next[z] = rsum_next[z] + ROW_W'(prod_reg[z*KERNEL_SIZE+j]);
            end
        end
    end

    // total plus bias
    always_comb begin
        sum_acc = '0;
        for (int z = 0; z < KERNEL_SIZE; z++) begin
            sum_acc = sum_acc + SUM_W'(rsum_reg[z]);
        end
        tot_next = TOT_W'(sum_acc) + TOT_W'(bias_reg);
    end

    // ReLU and saturation
    always_comb begin
        priority if (tot_reg[TOT_W-1]) begin
            relu_val = '0;
        end else if (|tot_reg[TOT_W-2:OUT_W]) begin
            relu_val = '1;
        end else begin
            relu_val = tot_reg[OUT_W-1:0];
        end
    end

    // valid bits of the stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (adv) begin
            v1_reg    <= q_valid && !q_entry.is_weight;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            out_v_reg <= v3_reg;
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < KAREA; k++) begin
                prod_reg[k] <= PROD_W'($signed({1'b0, q_entry.window[k]})) *
                               PROD_W'(wt_reg[k]);
            end
            t1_reg <= '{row: q_entry.out_row, col: q_entry.out_col, last: q_entry.last};
            for (int z = 0; z < KERNEL_SIZE; z++) begin
                rsum_reg[z] <= rsum_next[z];
            end
            t2_reg      <= t1_reg;
            tot_reg     <= tot_next;
            t3_reg      <= t2_reg;
            out_val_reg <= relu_val;
            out_t_reg   <= t3_reg;
        end
    end

    assign m_valid      = out_v_reg;
    assign m_conv_value = out_val_reg;
    assign m_out_row    = out_t_reg.row;
    assign m_out_col    = out_t_reg.col;
    assign m_last       = out_t_reg.last;

endmodule

`default_nettype wire
